@@ hdl/tod_pkg.sv @@
// Shared types and constants for the time-of-day clock.
package tod_pkg;

  // Field widths.
  localparam int UsW    = 14;
  localparam int FracW  = 16;
  localparam int MilliW = 10;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int DayMsW = 27;

  // Time constants.
  localparam logic [FracW-1:0]  FRAC_STEP   = 16'd1000;
  localparam logic [MilliW-1:0] MS_PER_SEC  = 10'd1000;
  localparam logic [DayMsW-1:0] MS_PER_HOUR = 27'd3600000;
  localparam logic [DayMsW-1:0] MS_PER_MIN  = 27'd60000;
  localparam logic [SecW-1:0]   SEC_LAST    = 6'd59;
  localparam logic [MinW-1:0]   MIN_LAST    = 6'd59;
  localparam logic [HourW-1:0]  HOUR_LAST   = 5'd23;
  localparam logic [UsW-1:0]    US_RESET    = 14'd640;

  // Request codes.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SUB,
    ST_SEC,
    ST_SETH,
    ST_SETM,
    ST_DONE
  } tod_state_t;

endpackage

@@ hdl/tod_req_if.sv @@
// Request channel: tick or set-time beats towards the clock.
interface tod_req_if
  import tod_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [HourW-1:0] set_hour;
  logic [MinW-1:0]  set_minute;

  modport source (output valid, output req_type, output set_hour, output set_minute,
                  input ready);
  modport sink   (input valid, input req_type, input set_hour, input set_minute,
                  output ready);
endinterface

@@ hdl/tod_rsp_if.sv @@
// Result channel: current time of day after each request.
interface tod_rsp_if
  import tod_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [HourW-1:0]  hour;
  logic [MinW-1:0]   minute;
  logic [SecW-1:0]   second;
  logic [DayMsW-1:0] day_millis;
  logic              second_event;
  logic              minute_event;

  modport source (output valid, output hour, output minute, output second,
                  output day_millis, output second_event, output minute_event,
                  input ready);
  modport sink   (input valid, input hour, input minute, input second,
                  input day_millis, input second_event, input minute_event,
                  output ready);
endinterface

@@ hdl/time_of_day_clock_core.sv @@
// Time-of-day clock core: fraction accumulator, time counters and result register.
//
// Usage: each beat on req is either a timer tick (req_type = 0) or a set request
// (req_type = 1, loading set_hour and set_minute, clamped to 23 and 59). Every
// beat yields exactly one beat on rsp with hour, minute, second, the millisecond
// of the day and the second and minute event flags for that tick. The user writes
// us_per_tick through cfg_we / cfg_data only while the block is idle (not enforced).
//
// Sequence: a tick passes through an add state; a subtract state, where each whole
// millisecond the tick adds (at most 17; at 640 us per tick 0 or 1) costs one pass
// through the single 16-bit add/subtract unit that serves the fraction accumulator;
// a seconds state that repeats once per second boundary; and a done state. A set
// request passes through the set-hour, set-minute and done states. req is ready
// only while the sequencer is idle, so one request is in flight at a time.
//
// Reset clears the time to midnight, the fraction and the millisecond count, and
// loads us_per_tick with 640. The result sits in an output register; a new
// request is accepted while it waits, and the sequencer holds its finished
// result until the receiver has taken the previous beat.
module time_of_day_clock_core
  import tod_pkg::*;
  (
    input  logic           clk,
    input  logic           rst,
    input  logic           cfg_we,
    input  logic [UsW-1:0] cfg_data,
    tod_req_if.sink        req,
    tod_rsp_if.source      rsp
  );

  tod_state_t state, state_next;

  logic [UsW-1:0]    us_per_tick;
  logic [FracW-1:0]  frac;
  logic [MilliW-1:0] milli;
  logic [SecW-1:0]   sec_reg;
  logic [MinW-1:0]   min_reg;
  logic [HourW-1:0]  hour_reg;
  logic [DayMsW-1:0] day_ms;
  logic              sec_ev;
  logic              min_ev;
  logic [HourW-1:0]  set_h;
  logic [MinW-1:0]   set_m;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic [FracW-1:0]  alu_b;
  logic [FracW-1:0]  alu_y;
  logic              frac_over;
  logic              milli_full;

  // Handshake and status terms.
  assign accept     = req.valid && req.ready;
  assign out_free   = !rsp.valid || rsp.ready;
  assign frac_over  = frac > FRAC_STEP;
  assign milli_full = milli >= MS_PER_SEC;

  // The shared unit: adds the tick length, or takes one millisecond off.
  always_comb begin
    if (state == ST_ADD) begin
      alu_b = {{(FracW-UsW){1'b0}}, us_per_tick};
    end else begin
      alu_b = ~FRAC_STEP + 16'd1;
    end
    alu_y = frac + alu_b;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (req.req_type == REQ_SET) ? ST_SETH : ST_ADD;
        end
      end
      ST_ADD:  state_next = ST_SUB;
      ST_SUB:  state_next = frac_over ? ST_SUB : ST_SEC;
      ST_SEC:  state_next = milli_full ? ST_SEC : ST_DONE;
      ST_SETH: state_next = ST_SETM;
      ST_SETM: state_next = ST_DONE;
      ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req.ready = (state == ST_IDLE);
    out_load  = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      us_per_tick <= US_RESET;
    end else if (cfg_we) begin
      us_per_tick <= cfg_data;
    end
  end

  // Request capture, with the set values clamped.
  always_ff @(posedge clk) begin
    if (accept) begin
      set_h <= (req.set_hour > HOUR_LAST) ? HOUR_LAST : req.set_hour;
      set_m <= (req.set_minute > MIN_LAST) ? MIN_LAST : req.set_minute;
    end
  end

  // Time-keeping state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frac     <= '0;
      milli    <= '0;
      sec_reg  <= '0;
      min_reg  <= '0;
      hour_reg <= '0;
      day_ms   <= '0;
      sec_ev   <= 1'b0;
      min_ev   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            sec_ev <= 1'b0;
            min_ev <= 1'b0;
          end
        end
        ST_ADD: begin
          frac <= alu_y;
        end
        ST_SUB: begin
          if (frac_over) begin
            frac   <= alu_y;
            day_ms <= day_ms + 27'd1;
            milli  <= milli + 10'd1;
          end
        end
        ST_SEC: begin
          // One second boundary per pass, rippling into minutes and hours.
          if (milli_full) begin
            milli  <= milli - MS_PER_SEC;
            sec_ev <= 1'b1;
            if (sec_reg >= SEC_LAST) begin
              sec_reg <= '0;
              min_ev  <= 1'b1;
              if (min_reg >= MIN_LAST) begin
                min_reg <= '0;
                if (hour_reg >= HOUR_LAST) begin
                  hour_reg <= '0;
                  day_ms   <= '0;
                end else begin
                  hour_reg <= hour_reg + 5'd1;
                end
              end else begin
                min_reg <= min_reg + 6'd1;
              end
            end else begin
              sec_reg <= sec_reg + 6'd1;
            end
          end
        end
        ST_SETH: begin
          hour_reg <= set_h;
          min_reg  <= set_m;
          sec_reg  <= '0;
          day_ms   <= {{(DayMsW-HourW){1'b0}}, set_h} * MS_PER_HOUR;
        end
        ST_SETM: begin
          day_ms <= day_ms + {{(DayMsW-MinW){1'b0}}, set_m} * MS_PER_MIN;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register towards the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.hour         <= hour_reg;
      rsp.minute       <= min_reg;
      rsp.second       <= sec_reg;
      rsp.day_millis   <= day_ms;
      rsp.second_event <= sec_ev;
      rsp.minute_event <= min_ev;
    end
  end

  // The fraction and millisecond count are fully reduced between requests.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (frac <= FRAC_STEP) && (milli < MS_PER_SEC))
    else $error("accumulator not reduced at idle");

  // The time counters stay in range.
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (sec_reg <= SEC_LAST) && (min_reg <= MIN_LAST) && (hour_reg <= HOUR_LAST))
    else $error("time counter out of range");

  // A finished result reaches the output register and the sequencer returns to idle.
  a_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> rsp.valid && (state == ST_IDLE))
    else $error("result not presented after completion");

  // Set requests never report events.
  a_set_no_event: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SETM) |-> !sec_ev && !min_ev)
    else $error("event flag raised on a set request");

endmodule
